>>> hdl/firmware_update_receiver_unit_assert.svh
// Assertion macros for the firmware update receiver.
`ifndef FIRMWARE_UPDATE_RECEIVER_UNIT_ASSERT_SVH
`define FIRMWARE_UPDATE_RECEIVER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define FURU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define FURU_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define FURU_ASSERT(lbl, prop, msg)
`define FURU_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

>>> hdl/frx_pkg.sv
// Types, constants and helpers shared by the firmware update receiver.
package frx_pkg;

    localparam int PAGE_BYTES      = 128;
    localparam int OFF_W           = $clog2(PAGE_BYTES);
    localparam int CFG_W           = 16;
    localparam int MAX_IMAGE_RESET = 28672;
    localparam int POS_W           = 5;
    localparam int POS_MAX         = 31;
    localparam int NSLOT           = 4;
    localparam int SLOT_W          = 2;

    localparam int SLOT_NOTIFY = 0;
    localparam int SLOT_FLASH  = 1;
    localparam int SLOT_COMMIT = 2;
    localparam int SLOT_RESP   = 3;

    typedef enum logic [2:0] {
        CMD_DATA      = 3'd0,
        CMD_INIT      = 3'd1,
        CMD_RECV      = 3'd2,
        CMD_VALIDATE  = 3'd3,
        CMD_ACTIVATE  = 3'd4,
        CMD_SYS_RESET = 3'd5,
        CMD_NOTIFY    = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_READY = 3'd1,
        PH_INIT  = 3'd2,
        PH_DATA  = 3'd3,
        PH_VALID = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        KIND_RESPONSE    = 3'd0,
        KIND_NOTIFY      = 3'd1,
        KIND_FLASH_BYTE  = 3'd2,
        KIND_PAGE_COMMIT = 3'd3,
        KIND_RADIO_RESET = 3'd4,
        KIND_ACTIVATE    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        PROC_START    = 2'd0,
        PROC_INIT     = 2'd1,
        PROC_IMAGE    = 2'd2,
        PROC_VALIDATE = 2'd3
    } t_proc;

    typedef enum logic {
        ST_SUCCESS    = 1'b0,
        ST_SIZE_ERROR = 1'b1
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  data_byte;
        logic        packet_last;
        logic [15:0] notify_interval;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        t_proc       procedure;
        t_status     status;
        logic [31:0] byte_count;
        logic [15:0] flash_address;
        logic [7:0]  flash_data;
    } t_result;

    typedef struct packed {
        logic [NSLOT-1:0]          pend;
        t_result [NSLOT-1:0]       res;
    } t_bundle;

    function automatic t_result mk_result(t_kind kind, t_proc procedure, t_status status,
                                          logic [31:0] count, logic [15:0] addr,
                                          logic [7:0] data);
        t_result r;
        r.kind          = kind;
        r.procedure     = procedure;
        r.status        = status;
        r.byte_count    = count;
        r.flash_address = addr;
        r.flash_data    = data;
        return r;
    endfunction

endpackage

>>> hdl/frx_core.sv
// Input register, update phase machine and per-word result bundle generation.
module frx_core import frx_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_item            i_item,
    output logic             o_bvalid,
    input  logic             i_bready,
    output t_bundle          o_bundle
);

    logic             r_in_valid;
    t_item            r_in;
    t_phase           r_phase, n_phase;
    logic [31:0]      r_image_size, n_image_size;
    logic [31:0]      r_bytes_rx, n_bytes_rx;
    logic [15:0]      r_page_base, n_page_base;
    logic [OFF_W-1:0] r_page_off, n_page_off;
    logic [15:0]      r_notify_target, n_notify_target;
    logic [15:0]      r_notify_cd, n_notify_cd;
    logic [POS_W-1:0] r_pkt_pos, n_pkt_pos;
    logic [CFG_W-1:0] r_max_image;

    logic             fire;
    logic             pos_first;
    logic [31:0]      size_new;
    logic             size_bad;
    logic [15:0]      cd_dec;
    logic             notify_hit;
    logic [OFF_W:0]   off_inc;
    logic             page_full;
    logic [31:0]      br_inc;
    logic             img_done;
    logic [POS_W-1:0] pos_next;
    t_bundle          bundle;

    assign fire       = r_in_valid && i_bready;
    assign o_in_ready = !r_in_valid || i_bready;

    assign pos_first  = (r_pkt_pos == '0);
    assign size_new   = (pos_first ? 32'd0 : r_image_size)
                      | ((r_pkt_pos[POS_W-1:2] == '0)
                         ? ({24'd0, r_in.data_byte} << {r_pkt_pos[1:0], 3'b000}) : 32'd0);
    assign size_bad   = (size_new == 32'd0) || (size_new > {16'd0, r_max_image});
    assign cd_dec     = r_notify_cd - 16'd1;
    assign notify_hit = pos_first && (r_notify_target != 16'd0) && (cd_dec == 16'd0);
    assign off_inc    = {1'b0, r_page_off} + (OFF_W+1)'(1);
    assign page_full  = (off_inc >= (OFF_W+1)'(PAGE_BYTES));
    assign br_inc     = r_bytes_rx + 32'd1;
    assign img_done   = r_in.packet_last && (br_inc == r_image_size);
    assign pos_next   = r_in.packet_last ? '0
                      : ((r_pkt_pos != POS_W'(POS_MAX)) ? r_pkt_pos + POS_W'(1) : r_pkt_pos);

    always_comb begin
        n_phase = r_phase;
        if (fire) begin
            unique case (r_in.cmd)
                CMD_DATA: begin
                    if (r_phase == PH_IDLE && r_in.packet_last && !size_bad) begin
                        n_phase = PH_READY;
                    end
                end
                CMD_INIT: begin
                    if (r_phase == PH_READY) begin
                        n_phase = PH_INIT;
                    end
                end
                CMD_RECV: begin
                    if (r_phase == PH_READY || r_phase == PH_INIT) begin
                        n_phase = PH_DATA;
                    end
                end
                CMD_VALIDATE: begin
                    if (r_phase == PH_DATA) begin
                        n_phase = PH_VALID;
                    end
                end
                CMD_SYS_RESET: n_phase = PH_IDLE;
                default: n_phase = r_phase;
            endcase
        end
    end

    always_comb begin
        n_image_size    = r_image_size;
        n_bytes_rx      = r_bytes_rx;
        n_page_base     = r_page_base;
        n_page_off      = r_page_off;
        n_notify_target = r_notify_target;
        n_notify_cd     = r_notify_cd;
        n_pkt_pos       = r_pkt_pos;
        bundle          = '0;
        if (fire) begin
            unique case (r_in.cmd)
                CMD_DATA: begin
                    n_pkt_pos = pos_next;
                    if (r_phase == PH_IDLE) begin
                        n_image_size = size_new;
                        if (r_in.packet_last) begin
                            bundle.pend[SLOT_RESP] = 1'b1;
                            bundle.res[SLOT_RESP]  = mk_result(KIND_RESPONSE, PROC_START,
                                size_bad ? ST_SIZE_ERROR : ST_SUCCESS, 32'd0, 16'd0, 8'd0);
                            if (!size_bad) begin
                                n_bytes_rx  = '0;
                                n_page_base = '0;
                                n_page_off  = '0;
                            end
                        end
                    end else if (r_phase == PH_INIT) begin
                        if (r_in.packet_last) begin
                            bundle.pend[SLOT_RESP] = 1'b1;
                            bundle.res[SLOT_RESP]  = mk_result(KIND_RESPONSE, PROC_INIT,
                                ST_SUCCESS, 32'd0, 16'd0, 8'd0);
                        end
                    end else if (r_phase == PH_DATA) begin
                        if (pos_first && r_notify_target != 16'd0) begin
                            n_notify_cd = notify_hit ? r_notify_target : cd_dec;
                        end
                        if (notify_hit) begin
                            bundle.pend[SLOT_NOTIFY] = 1'b1;
                            bundle.res[SLOT_NOTIFY]  = mk_result(KIND_NOTIFY, PROC_START,
                                ST_SUCCESS, r_bytes_rx, 16'd0, 8'd0);
                        end
                        bundle.pend[SLOT_FLASH] = 1'b1;
                        bundle.res[SLOT_FLASH]  = mk_result(KIND_FLASH_BYTE, PROC_START,
                            ST_SUCCESS, 32'd0, r_page_base + 16'(r_page_off), r_in.data_byte);
                        n_bytes_rx = br_inc;
                        // A full page and a completed image both close the current page.
                        if (page_full || img_done) begin
                            bundle.pend[SLOT_COMMIT] = 1'b1;
                            bundle.res[SLOT_COMMIT]  = mk_result(KIND_PAGE_COMMIT, PROC_START,
                                ST_SUCCESS, 32'd0, r_page_base, 8'd0);
                            n_page_base = r_page_base + 16'(PAGE_BYTES);
                            n_page_off  = '0;
                        end else begin
                            n_page_off = off_inc[OFF_W-1:0];
                        end
                        if (img_done) begin
                            bundle.pend[SLOT_RESP] = 1'b1;
                            bundle.res[SLOT_RESP]  = mk_result(KIND_RESPONSE, PROC_IMAGE,
                                ST_SUCCESS, 32'd0, 16'd0, 8'd0);
                        end
                    end
                end
                CMD_VALIDATE: begin
                    if (r_phase == PH_DATA && r_bytes_rx == r_image_size) begin
                        bundle.pend[SLOT_RESP] = 1'b1;
                        bundle.res[SLOT_RESP]  = mk_result(KIND_RESPONSE, PROC_VALIDATE,
                            ST_SUCCESS, 32'd0, 16'd0, 8'd0);
                    end
                end
                CMD_ACTIVATE: begin
                    if (r_phase == PH_VALID) begin
                        bundle.pend[SLOT_RESP] = 1'b1;
                        bundle.res[SLOT_RESP]  = mk_result(KIND_ACTIVATE, PROC_START,
                            ST_SUCCESS, 32'd0, 16'd0, 8'd0);
                    end
                end
                CMD_SYS_RESET: begin
                    n_pkt_pos              = '0;
                    bundle.pend[SLOT_RESP] = 1'b1;
                    bundle.res[SLOT_RESP]  = mk_result(KIND_RADIO_RESET, PROC_START,
                        ST_SUCCESS, 32'd0, 16'd0, 8'd0);
                end
                CMD_NOTIFY: begin
                    n_notify_target = r_in.notify_interval;
                    n_notify_cd     = r_in.notify_interval;
                end
                default: bundle = '0;
            endcase
        end
    end

    assign o_bvalid = fire && (bundle.pend != '0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_phase         <= PH_IDLE;
            r_image_size    <= '0;
            r_bytes_rx      <= '0;
            r_page_base     <= '0;
            r_page_off      <= '0;
            r_notify_target <= '0;
            r_notify_cd     <= '0;
            r_pkt_pos       <= '0;
            r_max_image     <= CFG_W'(MAX_IMAGE_RESET);
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_phase         <= n_phase;
            r_image_size    <= n_image_size;
            r_bytes_rx      <= n_bytes_rx;
            r_page_base     <= n_page_base;
            r_page_off      <= n_page_off;
            r_notify_target <= n_notify_target;
            r_notify_cd     <= n_notify_cd;
            r_pkt_pos       <= n_pkt_pos;
            if (i_cfg_we) begin
                r_max_image <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_item;
        end
    end

endmodule

>>> hdl/frx_seq.sv
// Result bundle register and output register that deliver one result word per cycle while the output is not stalled.
module frx_seq import frx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_bvalid,
    output logic    o_bready,
    input  t_bundle i_bundle,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result,
    output logic    o_last
);

    logic                r_bvalid;
    logic [NSLOT-1:0]    r_pend, n_pend;
    t_result [NSLOT-1:0] r_res;
    logic                r_ovalid;
    t_result             r_out;
    logic                r_last;

    logic                out_free;
    logic                pop;
    logic [SLOT_W-1:0]   sel;
    logic                sel_last;

    always_comb begin
        sel = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    assign n_pend   = r_pend & ~(NSLOT'(1) << sel);
    assign sel_last = (n_pend == '0);
    assign out_free = !r_ovalid || i_ready;
    assign pop      = r_bvalid && out_free;
    assign o_bready = !r_bvalid || (out_free && sel_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= 1'b0;
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_bvalid && o_bready) begin
                r_bvalid <= 1'b1;
                r_pend   <= i_bundle.pend;
            end else if (pop) begin
                r_bvalid <= !sel_last;
                r_pend   <= n_pend;
            end
            if (out_free) begin
                r_ovalid <= pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bvalid && o_bready) begin
            r_res <= i_bundle.res;
        end
        if (pop) begin
            r_out  <= r_res[sel];
            r_last <= sel_last;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_result = r_out;
    assign o_last   = r_last;

endmodule

>>> hdl/firmware_update_receiver_unit.sv
// A word passes the input register, the result bundle register and the output register
// before its first result word shows. One input word per cycle when it yields at most one
// result word and the output does not stall; otherwise input waits until the bundle drains.
// Up to four result words per input word; the output register sets the delivery rate.
// Reset is synchronous and active low; it clears the phase, counters and handshakes and
// restores the maximum image size register to 28672.
`include "firmware_update_receiver_unit_assert.svh"
module firmware_update_receiver_unit import frx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // data_byte[7:0], notify_interval[23:8]
    input  logic [2:0]  i_s_tuser,   // cmd[2:0]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // procedure[1:0], status[2], byte_count[34:3],
                                     // flash_address[50:35], flash_data[58:51], zero[63:59]
    output logic [2:0]  o_m_tuser,   // kind[2:0]
    output logic        o_m_tlast
);

    t_item   item;
    logic    bvalid;
    logic    bready;
    t_bundle bundle;
    t_result result;
    logic    last;
    logic    out_resp;
    logic    out_notify;
    logic    out_stall;

    assign item.cmd             = t_cmd'(i_s_tuser);
    assign item.data_byte       = i_s_tdata[7:0];
    assign item.packet_last     = i_s_tlast;
    assign item.notify_interval = i_s_tdata[23:8];

    frx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_item      (item),
        .o_bvalid    (bvalid),
        .i_bready    (bready),
        .o_bundle    (bundle)
    );

    frx_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bvalid (bvalid),
        .o_bready (bready),
        .i_bundle (bundle),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (result),
        .o_last   (last)
    );

    assign o_m_tdata = {5'd0, result.flash_data, result.flash_address, result.byte_count,
                        result.status, result.procedure};
    assign o_m_tuser = result.kind;
    assign o_m_tlast = last;

    assign out_resp   = o_m_tvalid && (o_m_tuser == KIND_RESPONSE);
    assign out_notify = o_m_tvalid && (o_m_tuser == KIND_NOTIFY);
    assign out_stall  = o_m_tvalid && !i_m_tready;

    `FURU_ASSERT_ANY(a_reset_idle, !i_rst_n |=> !o_m_tvalid, "output valid after reset")
    `FURU_ASSERT(a_resp_last, out_resp |-> o_m_tlast, "response not last")
    `FURU_ASSERT(a_notify_not_last, out_notify |-> !o_m_tlast, "notification marked last")
    `FURU_ASSERT(a_out_hold, out_stall |=> o_m_tvalid && $stable(o_m_tdata), "stalled word changed")

endmodule
